// File: hdl/nsts_pkg.sv
// ----------------------------------------------------------------------------
// nsts_pkg
// Shared types and codes of the nested string token scanner: the input word,
// the result word and the job that carries the results of one text byte.
// ----------------------------------------------------------------------------
package nsts_pkg;

   // Result kinds.
   localparam logic [1:0] KIND_CHAR = 2'd0;
   localparam logic [1:0] KIND_END  = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   // One byte causes at most three results.
   localparam int SLOTS = 3;

   // Job queue between front and back.
   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = 2;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       line_end;
   } req_type;

   typedef struct packed {
      logic [1:0] result_kind;
      logic [7:0] char_value;
      logic       last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] ch;
   } slot_type;

   typedef struct packed {
      logic [1:0]                count;
      slot_type [SLOTS-1:0]      slot;
   } job_type;

endpackage

// File: hdl/nsts_front.sv
// ----------------------------------------------------------------------------
// nsts_front
// Accepts text bytes, tracks the scanner state and turns each byte into a
// job of zero to three results for the job queue.
// ----------------------------------------------------------------------------
module nsts_front
   import nsts_pkg::*;
#(
   parameter int MAX_NEST = 255
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   input  logic    q_full,
   output logic    q_push,
   output job_type q_job
);

   localparam int DEPTH_W = $clog2(MAX_NEST + 1);

   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_RBRACK  = 8'h5D;
   localparam logic [7:0] CH_N       = 8'h6E;
   localparam logic [7:0] CH_T       = 8'h74;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;

   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic               tok_ff, tok_in;
   logic               esc_ff, esc_in;
   logic               skip_ff, skip_in;
   logic               accept;
   job_type            job;
   logic [7:0]         c;
   logic               eol;

   function automatic job_type add_result(job_type j, logic [1:0] kind, logic [7:0] ch);
      job_type r;
      r = j;
      if (r.count != 2'd3) begin
         r.slot[r.count].kind = kind;
         r.slot[r.count].ch   = ch;
         r.count              = r.count + 2'd1;
      end
      return r;
   endfunction

   assign accept = req_push && !q_full;
   assign c      = req_data.text_byte;
   assign eol    = req_data.line_end;

   always_comb begin
      job      = '0;
      depth_in = depth_ff;
      tok_in   = tok_ff;
      esc_in   = esc_ff;
      skip_in  = skip_ff;
      if (skip_ff) begin
         if (eol) begin
            skip_in = 1'b0;
         end
      end else begin
         if (depth_ff != '0) begin
            if (esc_ff) begin
               esc_in = 1'b0;
               priority if (c == CH_N) begin
                  job = add_result(job, KIND_CHAR, CH_LF);
               end else if (c == CH_T) begin
                  job = add_result(job, KIND_CHAR, CH_TAB);
               end else if (c == CH_ZERO) begin
                  job = add_result(job, KIND_CHAR, CH_NUL);
               end else begin
                  job = add_result(job, KIND_CHAR, CH_BSLASH);
                  job = add_result(job, KIND_CHAR, c);
               end
            end else begin
               unique case (c)
                  CH_BSLASH: begin
                     if (eol) begin
                        job = add_result(job, KIND_CHAR, CH_BSLASH);
                     end else begin
                        esc_in = 1'b1;
                     end
                  end
                  CH_LPAREN: begin
                     if (depth_ff < DEPTH_W'(MAX_NEST)) begin
                        depth_in = depth_ff + DEPTH_W'(1);
                     end
                     job = add_result(job, KIND_CHAR, c);
                  end
                  CH_RPAREN: begin
                     depth_in = depth_ff - DEPTH_W'(1);
                     job      = add_result(job, KIND_CHAR, c);
                     if (depth_in == '0) begin
                        job    = add_result(job, KIND_END, CH_NUL);
                        tok_in = 1'b0;
                     end
                  end
                  default: begin
                     job = add_result(job, KIND_CHAR, c);
                  end
               endcase
            end
         end else begin
            unique case (c)
               CH_SPACE, CH_TAB, CH_LF: begin
                  if (tok_ff) begin
                     job = add_result(job, KIND_END, CH_NUL);
                  end
                  tok_in = 1'b0;
               end
               CH_SLASH: begin
                  if (tok_ff) begin
                     job = add_result(job, KIND_END, CH_NUL);
                  end
                  job    = add_result(job, KIND_CHAR, c);
                  tok_in = 1'b1;
               end
               CH_LPAREN: begin
                  if (tok_ff) begin
                     job = add_result(job, KIND_END, CH_NUL);
                  end
                  job      = add_result(job, KIND_CHAR, c);
                  tok_in   = 1'b0;
                  depth_in = DEPTH_W'(1);
               end
               CH_RPAREN: begin
                  // The open token is abandoned without a token end.
                  job     = add_result(job, KIND_ERR, CH_NUL);
                  tok_in  = 1'b0;
                  skip_in = 1'b1;
               end
               CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE: begin
                  if (tok_ff) begin
                     job = add_result(job, KIND_END, CH_NUL);
                  end
                  job    = add_result(job, KIND_CHAR, c);
                  job    = add_result(job, KIND_END, CH_NUL);
                  tok_in = 1'b0;
               end
               CH_PERCENT, CH_SEMI: begin
                  if (tok_ff) begin
                     job = add_result(job, KIND_END, CH_NUL);
                  end
                  tok_in  = 1'b0;
                  skip_in = 1'b1;
               end
               CH_BSLASH: begin
               end
               default: begin
                  job    = add_result(job, KIND_CHAR, c);
                  tok_in = 1'b1;
               end
            endcase
         end
         // End of line closes a token outside strings and ends any skip.
         if (eol) begin
            if (depth_in == '0 && tok_in) begin
               job    = add_result(job, KIND_END, CH_NUL);
               tok_in = 1'b0;
            end
            skip_in = 1'b0;
            esc_in  = 1'b0;
         end
      end
   end

   assign q_push = accept && (job.count != 2'd0);
   assign q_job  = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         tok_ff   <= 1'b0;
         esc_ff   <= 1'b0;
         skip_ff  <= 1'b0;
      end else if (accept) begin
         depth_ff <= depth_in;
         tok_ff   <= tok_in;
         esc_ff   <= esc_in;
         skip_ff  <= skip_in;
      end
   end

endmodule

// File: hdl/nsts_queue.sv
// ----------------------------------------------------------------------------
// nsts_queue
// Short first-in first-out queue of jobs between the front and the back.
// ----------------------------------------------------------------------------
module nsts_queue
   import nsts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output job_type head_job
);

   job_type         entry_ff [Q_DEPTH];
   logic [Q_AW:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_AW:0]   rd_ptr_ff, rd_ptr_in;
   logic            do_push, do_pop;

   assign empty    = (wr_ptr_ff == rd_ptr_ff);
   assign full     = (wr_ptr_ff[Q_AW] != rd_ptr_ff[Q_AW]) &&
                     (wr_ptr_ff[Q_AW-1:0] == rd_ptr_ff[Q_AW-1:0]);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = entry_ff[rd_ptr_ff[Q_AW-1:0]];

   assign wr_ptr_in = do_push ? wr_ptr_ff + (Q_AW+1)'(1) : wr_ptr_ff;
   assign rd_ptr_in = do_pop  ? rd_ptr_ff + (Q_AW+1)'(1) : rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff[Q_AW-1:0]] <= push_job;
      end
   end

endmodule

// File: hdl/nsts_back.sv
// ----------------------------------------------------------------------------
// nsts_back
// Takes jobs from the queue and hands out their results through a result
// register one word per cycle while taken, marking each byte's last result.
// ----------------------------------------------------------------------------
module nsts_back
   import nsts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   input  job_type q_head,
   output logic    q_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   rsp_type    out_ff, out_in;
   logic       load;
   logic       last;

   // A new word enters the result register when it is empty or being taken.
   assign load  = !q_empty && (!valid_ff || rsp_pop);
   assign last  = (idx_ff == q_head.count - 2'd1);
   assign q_pop = load && last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      out_in   = out_ff;
      if (load) begin
         out_in.result_kind = q_head.slot[idx_ff].kind;
         out_in.char_value  = q_head.slot[idx_ff].ch;
         out_in.last_of_run = last;
         valid_in           = 1'b1;
         idx_in             = last ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_empty = !valid_ff;
   assign rsp_data  = out_ff;

endmodule

// File: hdl/nested_string_token_scanner.sv
// ----------------------------------------------------------------------------
// nested_string_token_scanner
// PostScript-style tokenizer: text bytes in, token characters, token ends and
// unmatched close paren errors out.
// ----------------------------------------------------------------------------
// Input queue: write a text byte and its end-of-line mark on req_data with
// req_push; the byte is taken at a clock edge where req_full is low. Result
// queue: while rsp_empty is low the oldest result word is on rsp_data, and it
// is taken at an edge where rsp_pop is high. Each byte gives zero to three
// result words; last_of_run marks the final word of a byte.
// The first result of a byte passes the job queue and the result register
// before it shows on rsp_data. The front takes one byte per cycle while
// req_full is low; the result register hands out one word per cycle while
// the receiver takes it, so a byte with several words needs more output
// bandwidth. A four-job queue between front and back absorbs such bursts;
// req_full rises only when that queue is full. A stalled receiver holds its
// word on rsp_data and fills the queue, after which req_full holds off new
// bytes. Synchronous reset clears the scanner state (string depth, open token,
// escape, line skip) and empties both queues; no word is pending after reset.
// ----------------------------------------------------------------------------
module nested_string_token_scanner
   import nsts_pkg::*;
#(
   parameter int MAX_NEST = 255
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic    q_push;
   job_type q_job;
   logic    q_full;
   logic    q_pop;
   logic    q_empty;
   job_type q_head;

   nsts_front #(
      .MAX_NEST (MAX_NEST)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_job    (q_job)
   );

   nsts_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_job),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head_job (q_head)
   );

   nsts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   assign req_full = q_full;

endmodule

// File: hdl/nsts_checker.sv
// ----------------------------------------------------------------------------
// nsts_checker
// Port-level checks of the scanner's result queue and its reset behavior.
// ----------------------------------------------------------------------------
module nsts_checker
   import nsts_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_full,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_data
);

   // Both queues come out of reset empty.
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // A waiting word holds until it is taken.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("result word changed while stalled");

   a_kind: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.result_kind == KIND_CHAR ||
                      rsp_data.result_kind == KIND_END ||
                      rsp_data.result_kind == KIND_ERR))
      else $error("undefined result kind");

   // Token ends and errors carry no character.
   a_no_char: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.result_kind != KIND_CHAR) |-> (rsp_data.char_value == 8'h00))
      else $error("character on a non-character result");

   // An error is always the only word of its byte.
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.result_kind == KIND_ERR) |-> rsp_data.last_of_run)
      else $error("error result not last of its byte");

endmodule

bind nested_string_token_scanner nsts_checker u_checker (.*);
